[sv/assert_macros.svh]
// Assertion shorthands used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/skel_pkg.sv]
package skel_pkg;

   localparam int FW_BITS         = 12;
   localparam int FH_BITS         = 13;
   localparam int CSR_DATA_WIDTH  = 13;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int COUNT_WIDTH     = 4;
   localparam int KIND_WIDTH      = 2;
   localparam int MIN_SIZE        = 3;
   localparam int JUNCTION_MIN    = 3;

   localparam logic [FW_BITS-1:0] RESET_FRAME_WIDTH  = FW_BITS'(640);
   localparam logic [FH_BITS-1:0] RESET_FRAME_HEIGHT = FH_BITS'(480);

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FRAME_HEIGHT = 1'b1;

   typedef enum logic [KIND_WIDTH-1:0] {
      NODE_NONE     = 2'd0,
      NODE_ENDPOINT = 2'd1,
      NODE_JUNCTION = 2'd2
   } node_kind_type;

endpackage

[sv/skel_ram.sv]
module skel_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/skeleton_node_classifier.sv]
// channel | handshake              | payload
// req     | req_valid / req_ready  | req_skel_bit, req_frame_start
// rsp     | rsp_valid / rsp_ready  | rsp_center_x/y/set, rsp_neighbour_count, rsp_node_kind,
//         |                        | rsp_frame_end
// csr     | csr_we (no wait)       | csr_index, csr_wdata
//
// One pixel per cycle while neither the clearing pass nor a stall on rsp holds intake;
// a taken pixel passes the line store read, then window and count into the result register.
// After reset a clearing pass zeroes all MAX_WIDTH entries of the line store;
// req_ready stays low meanwhile, csr writes are taken.
// A stall on rsp holds only pixels that produce a result; others drain.
module skeleton_node_classifier #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096,
   localparam int XW = $clog2(MAX_WIDTH),
   localparam int YW = $clog2(MAX_HEIGHT)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_skel_bit,
   input  logic                                 req_frame_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [XW-1:0]                        rsp_center_x,
   output logic [YW-1:0]                        rsp_center_y,
   output logic                                 rsp_center_set,
   output logic [skel_pkg::COUNT_WIDTH-1:0]     rsp_neighbour_count,
   output logic [skel_pkg::KIND_WIDTH-1:0]      rsp_node_kind,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_we,
   input  logic [skel_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [skel_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   import skel_pkg::*;

   `include "assert_macros.svh"

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [FW_BITS-1:0] frame_width_ff, frame_width_in;
   logic [FH_BITS-1:0] frame_height_ff, frame_height_in;
   logic [WW-1:0]      width_lim;
   logic [HW-1:0]      height_lim;

   logic               clr_active_ff, clr_active_in;
   logic [XW-1:0]      clr_addr_ff, clr_addr_in;

   logic [XW-1:0]      col_ff, col_in, col_base;
   logic [YW-1:0]      row_ff, row_in, row_base;
   logic               col_wrap, row_wrap, s0_emit, s0_last, req_acc;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_pix_ff, s1_pix_in;
   logic               s1_start_ff, s1_start_in;
   logic               s1_emit_ff, s1_emit_in;
   logic               s1_last_ff, s1_last_in;
   logic [XW-1:0]      s1_x_ff, s1_x_in;
   logic [YW-1:0]      s1_y_ff, s1_y_in;
   logic               s1_adv, out_free;

   logic [1:0]         ram_rdata, ram_wdata;
   logic [XW-1:0]      ram_waddr;
   logic               ram_we;

   logic [8:0]         window_ff, window_in;
   logic               centre;
   logic [COUNT_WIDTH-1:0] count;
   node_kind_type      kind;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0]      rsp_x_ff, rsp_x_in;
   logic [YW-1:0]      rsp_y_ff, rsp_y_in;
   logic               rsp_set_ff, rsp_set_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   node_kind_type      rsp_kind_ff, rsp_kind_in;
   logic               rsp_end_ff, rsp_end_in;

   // config registers
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_wdata[FW_BITS-1:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_wdata[FH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff < FW_BITS'(MIN_SIZE)) begin
         width_lim = WW'(MIN_SIZE);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         width_lim = WW'(MAX_WIDTH);
      end else begin
         width_lim = WW'(frame_width_ff);
      end
      if (frame_height_ff < FH_BITS'(MIN_SIZE)) begin
         height_lim = HW'(MIN_SIZE);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         height_lim = HW'(MAX_HEIGHT);
      end else begin
         height_lim = HW'(frame_height_ff);
      end
   end

   // clearing pass over the line store
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + XW'(1);
         if (clr_addr_ff == XW'(MAX_WIDTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   // position of the incoming pixel
   always_comb begin
      col_base = req_frame_start ? '0 : col_ff;
      row_base = req_frame_start ? '0 : row_ff;
      col_wrap = (WW'(col_base) + WW'(1)) >= width_lim;
      row_wrap = (HW'(row_base) + HW'(1)) >= height_lim;
      s0_emit  = (col_base >= XW'(2)) && (row_base >= YW'(2))
                 && (WW'(col_base) < width_lim) && (HW'(row_base) < height_lim);
      s0_last  = (WW'(col_base) == width_lim - WW'(1))
                 && (HW'(row_base) == height_lim - HW'(1));
      col_in   = col_ff;
      row_in   = row_ff;
      if (req_acc) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_base + YW'(1);
         end else begin
            col_in = col_base + XW'(1);
            row_in = row_base;
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_ready = !clr_active_ff && (!s1_valid_ff || s1_adv);
   assign req_acc   = req_valid && req_ready;

   // window stage
   always_comb begin
      s1_valid_in = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_pix_in   = req_acc ? req_skel_bit    : s1_pix_ff;
      s1_start_in = req_acc ? req_frame_start : s1_start_ff;
      s1_emit_in  = req_acc ? s0_emit         : s1_emit_ff;
      s1_last_in  = req_acc ? s0_last         : s1_last_ff;
      s1_x_in     = req_acc ? col_base        : s1_x_ff;
      s1_y_in     = req_acc ? row_base        : s1_y_ff;
   end

   // bit 0 is the row two above, bit 1 the row just above
   assign ram_we    = clr_active_ff || s1_adv;
   assign ram_waddr = clr_active_ff ? clr_addr_ff : s1_x_ff;
   assign ram_wdata = clr_active_ff ? 2'b00 : {s1_pix_ff, ram_rdata[1]};

   skel_ram #(
      .WIDTH (2),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (req_acc),
      .raddr (col_base),
      .rdata (ram_rdata)
   );

   always_comb begin
      window_in = window_ff;
      if (s1_adv) begin
         window_in = {(s1_start_ff ? 6'd0 : window_ff[5:0]),
                      s1_pix_ff, ram_rdata[1], ram_rdata[0]};
      end
   end

   always_comb begin
      logic [8:0] win;
      win    = {(s1_start_ff ? 6'd0 : window_ff[5:0]), s1_pix_ff, ram_rdata[1], ram_rdata[0]};
      centre = win[4];
      count  = '0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) begin
            count = count + COUNT_WIDTH'(win[i]);
         end
      end
      if (!centre) begin
         count = '0;
      end
      priority if (centre && count == COUNT_WIDTH'(1)) begin
         kind = NODE_ENDPOINT;
      end else if (centre && count >= COUNT_WIDTH'(JUNCTION_MIN)) begin
         kind = NODE_JUNCTION;
      end else begin
         kind = NODE_NONE;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_set_in   = rsp_set_ff;
      rsp_count_in = rsp_count_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_end_in   = rsp_end_ff;
      if (s1_adv && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = s1_x_ff - XW'(1);
         rsp_y_in     = s1_y_ff - YW'(1);
         rsp_set_in   = centre;
         rsp_count_in = count;
         rsp_kind_in  = kind;
         rsp_end_in   = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_FRAME_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
         clr_active_ff   <= 1'b1;
         clr_addr_ff     <= '0;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         window_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         clr_active_ff   <= clr_active_in;
         clr_addr_ff     <= clr_addr_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= s1_valid_in;
         window_ff       <= window_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff    <= s1_pix_in;
      s1_start_ff  <= s1_start_in;
      s1_emit_ff   <= s1_emit_in;
      s1_last_ff   <= s1_last_in;
      s1_x_ff      <= s1_x_in;
      s1_y_ff      <= s1_y_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_set_ff   <= rsp_set_in;
      rsp_count_ff <= rsp_count_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_center_x        = rsp_x_ff;
   assign rsp_center_y        = rsp_y_ff;
   assign rsp_center_set      = rsp_set_ff;
   assign rsp_neighbour_count = rsp_count_ff;
   assign rsp_node_kind       = rsp_kind_ff;
   assign rsp_frame_end       = rsp_end_ff;

   `ASSERT_NOW(a_clear_blocks_intake, clock, reset, clr_active_ff, !req_ready)
   `ASSERT_NOW(a_silent_word_drains, clock, reset, s1_valid_ff && !s1_emit_ff, s1_adv)
   `ASSERT_NEXT(a_emit_reaches_output, clock, reset, s1_adv && s1_emit_ff, rsp_valid)
   `ASSERT_NOW(a_clear_centre_is_none, clock, reset, rsp_valid && !rsp_center_set, rsp_neighbour_count == '0 && rsp_node_kind == NODE_NONE)

endmodule
